// ===== src/mwcsng_pkg.sv =====
// types and constants shared by the nonce generator modules
`default_nettype none
package mwcsng_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;

  localparam logic [31:0] SeedAOffset = 32'h5554_3DC3;
  localparam logic [31:0] SeedBOffset = 32'hAAAA_E44E;
  localparam logic [15:0] MulA        = 16'h5D7F;
  localparam logic [15:0] MulB        = 16'h8CA0;

  localparam logic ActSync = 1'b0;
  localparam logic ActNext = 1'b1;

  localparam logic RegLot = 1'b0;
  localparam logic RegSid = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] seed;
  } in_word_t;

  typedef struct packed {
    logic [31:0] nonce;
    logic        valid_res;
  } out_word_t;

  typedef enum logic [1:0] {
    StIdle,
    StSeed,
    StFill,
    StNext
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
  } tbl_ctrl_t;

endpackage
`default_nettype wire

// ===== src/mwc_shuffled_nonce_generator_unit.sv =====
// top level of the shuffled multiply-with-carry nonce generator
//
//   port group  dir  handshake            word
//   in_*        in   in_valid_i/ready_o   action, seed
//   out_*       out  out_valid_o/ready_i  nonce, valid_res
//   cfg_*       in   cfg_we_i             0 lot_number, 1 sequence_id
//
// a next word reads the table at accept; write-back and result follow in StNext
// a sync word runs the accept, one seed load, then 16 generator steps
// with each table write in the cycle after its step, through the single write port
// no clearing pass after reset; words are taken only in the idle state
// a result waiting in the output register stalls the next word in its final cycle
`default_nettype none
module mwc_shuffled_nonce_generator_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire mwcsng_pkg::in_word_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output mwcsng_pkg::out_word_t      out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [31:0]           cfg_data_i
);
  import mwcsng_pkg::*;

  state_e          state_q, state_d;
  logic [31:0]     lot_q, sid_q;
  logic [7:0]      seed_q;
  logic [CntW-1:0] fill_cnt_q;
  logic [IdxW-1:0] index_q;
  logic            synced_q;
  logic            out_valid_q;
  out_word_t       out_q;

  gen_ctrl_t       gen_ctrl;
  tbl_ctrl_t       tbl_ctrl;
  logic [31:0]     seed_a, seed_b;
  logic [31:0]     mix;
  logic [IdxW-1:0] idx_sum;
  logic [31:0]     rd_data;
  logic            in_acc;
  logic            out_free;
  logic            fill_last;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign fill_last = fill_cnt_q == CntW'(TableDepth);

  assign seed_a = 32'(lot_q[15:0]) + SeedAOffset + 32'(lot_q[31:16]) + 32'(seed_q);
  assign seed_b = 32'(sid_q[15:0]) + SeedBOffset + 32'(sid_q[31:16]);

  mwcsng_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (gen_ctrl),
    .seed_a_i  (seed_a),
    .seed_b_i  (seed_b),
    .mix_o     (mix),
    .idx_sum_o (idx_sum)
  );

  mwcsng_table u_table (
    .clk_i     (clk_i),
    .ctrl_i    (tbl_ctrl),
    .wr_data_i (mix),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = (in_data_i.action == ActSync) ? StSeed : StNext;
        end
      end
      StSeed: state_d = StFill;
      StFill: begin
        if (fill_last) begin
          state_d = StIdle;
        end
      end
      StNext: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = 1'b0;
    gen_ctrl         = '0;
    tbl_ctrl         = '0;
    tbl_ctrl.rd_addr = index_q;
    tbl_ctrl.wr_addr = index_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_acc && in_data_i.action == ActNext && synced_q) begin
          tbl_ctrl.rd_en = 1'b1;
          gen_ctrl.step  = 1'b1;
        end
      end
      StSeed: gen_ctrl.load = 1'b1;
      StFill: begin
        gen_ctrl.step    = !fill_last;
        tbl_ctrl.wr_en   = fill_cnt_q != '0;
        tbl_ctrl.wr_addr = fill_cnt_q[IdxW-1:0] - IdxW'(1);
      end
      StNext: begin
        tbl_ctrl.wr_en = out_free && synced_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seed_q <= in_data_i.seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lot_q       <= '0;
      sid_q       <= '0;
      fill_cnt_q  <= '0;
      index_q     <= '0;
      synced_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegLot) begin
          lot_q <= cfg_data_i;
        end else begin
          sid_q <= cfg_data_i;
        end
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StSeed: fill_cnt_q <= '0;
        StFill: begin
          fill_cnt_q <= fill_cnt_q + CntW'(1);
          if (fill_last) begin
            index_q  <= idx_sum;
            synced_q <= 1'b1;
          end
        end
        StNext: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (synced_q) begin
              out_q.nonce     <= rd_data;
              out_q.valid_res <= 1'b1;
              index_q         <= rd_data[IdxW-1:0];
            end else begin
              out_q.nonce     <= '0;
              out_q.valid_res <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== src/mwcsng_gen.sv =====
// pair of multiply-with-carry generator registers with seed load and step
`default_nettype none
module mwcsng_gen (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mwcsng_pkg::gen_ctrl_t ctrl_i,
  input  wire logic [31:0]           seed_a_i,
  input  wire logic [31:0]           seed_b_i,
  output logic [31:0]                mix_o,
  output logic [mwcsng_pkg::IdxW-1:0] idx_sum_o
);
  import mwcsng_pkg::*;

  logic [31:0] gen_a_q, gen_a_d;
  logic [31:0] gen_b_q, gen_b_d;
  logic [31:0] prod_a, prod_b;

  assign prod_a = 32'(gen_a_q[15:0]) * 32'(MulA);
  assign prod_b = 32'(gen_b_q[15:0]) * 32'(MulB);

  always_comb begin
    gen_a_d = gen_a_q;
    gen_b_d = gen_b_q;
    if (ctrl_i.load) begin
      gen_a_d = seed_a_i;
      gen_b_d = seed_b_i;
    end else if (ctrl_i.step) begin
      gen_a_d = {16'h0000, gen_a_q[31:16]} + prod_a;
      gen_b_d = {16'h0000, gen_b_q[31:16]} + prod_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_a_q <= '0;
      gen_b_q <= '0;
    end else begin
      gen_a_q <= gen_a_d;
      gen_b_q <= gen_b_d;
    end
  end

  assign mix_o     = gen_b_q + {gen_a_q[15:0], 16'h0000};
  assign idx_sum_o = gen_a_q[IdxW-1:0] + gen_b_q[IdxW-1:0];

endmodule
`default_nettype wire

// ===== src/mwcsng_table.sv =====
// shuffle table memory, one write and one registered read per cycle
`default_nettype none
module mwcsng_table (
  input  wire logic                  clk_i,
  input  wire mwcsng_pkg::tbl_ctrl_t ctrl_i,
  input  wire logic [31:0]           wr_data_i,
  output logic [31:0]                rd_data_o
);
  import mwcsng_pkg::*;

  logic [31:0] mem [TableDepth];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[ctrl_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire
